// File: rtl/core/clnib_pkg.sv
// shared types, codes and tables for the character display nibble interface
`default_nettype none

package clnib_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_CHAR  = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_LINE1 = 3'd3;
    localparam logic [2:0] CMD_LINE2 = 3'd4;
    localparam logic [2:0] CMD_RAW   = 3'd5;

    localparam logic [7:0] BYTE_CLEAR = 8'h01;
    localparam logic [7:0] BYTE_LINE1 = 8'h80;
    localparam logic [7:0] BYTE_LINE2 = 8'hC0;

    localparam logic [3:0] INIT_LAST_IDX = 4'd13;
    localparam logic [3:0] BYTE_LAST_IDX = 4'd1;
    localparam logic [3:0] WRAP_LAST_IDX = 4'd3;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_BYTE,
        JOB_WRAP
    } t_job_kind;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last;
        logic [3:0] cursor_column;
        logic       cursor_row;
    } t_out_item;

    // one classified item waiting for the bus sequencer
    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic [7:0] first_byte;
        logic [7:0] wrap_byte;
        logic [3:0] column;
        logic       row;
    } t_job;

    // power-up sequence: four single nibbles, then five bytes as nibble pairs
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'hC;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'hC;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h6;
            4'd10:   nib = 4'h1;
            4'd11:   nib = 4'h4;
            4'd12:   nib = 4'h0;
            4'd13:   nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/clnib_front.sv
// front end: accepts items, tracks the cursor and builds bus jobs
`default_nettype none

module clnib_front
    import clnib_pkg::*;
#(
    parameter int COLUMNS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_item,
    output logic          o_in_stall,
    input  wire logic     i_full,
    output logic          o_push,
    output t_job          o_job
);

    localparam logic [3:0] LastCol = 4'(COLUMNS - 1);

    logic [3:0] r_col, n_col;
    logic       r_row, n_row;
    logic       accept;
    logic       known;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_col            = r_col;
        n_row            = r_row;
        known            = 1'b1;
        o_job.kind       = JOB_BYTE;
        o_job.rs         = 1'b0;
        o_job.first_byte = i_in_item.data_byte;
        o_job.wrap_byte  = BYTE_LINE2;
        case (i_in_item.command)
            CMD_INIT: begin
                o_job.kind = JOB_INIT;
                n_col      = 4'd0;
                n_row      = 1'b0;
            end
            CMD_CHAR: begin
                o_job.rs = 1'b1;
                if (r_col == LastCol) begin
                    // wrap to column 0 of the other line
                    o_job.kind      = JOB_WRAP;
                    o_job.wrap_byte = r_row ? BYTE_LINE1 : BYTE_LINE2;
                    n_col           = 4'd0;
                    n_row           = !r_row;
                end else begin
                    n_col = r_col + 4'd1;
                end
            end
            CMD_CLEAR: begin
                o_job.first_byte = BYTE_CLEAR;
                n_col            = 4'd0;
                n_row            = 1'b0;
            end
            CMD_LINE1: begin
                o_job.first_byte = BYTE_LINE1;
                n_col            = 4'd0;
                n_row            = 1'b0;
            end
            CMD_LINE2: begin
                o_job.first_byte = BYTE_LINE2;
                n_col            = 4'd0;
                n_row            = 1'b1;
            end
            CMD_RAW: begin
                o_job.first_byte = i_in_item.data_byte;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        o_job.column = n_col;
        o_job.row    = n_row;
    end

    // unknown codes are taken and dropped
    assign o_push = accept && known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 4'd0;
            r_row <= 1'b0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/clnib_queue.sv
// short job queue between front end and bus sequencer
`default_nettype none

module clnib_queue
    import clnib_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam logic [QueuePtrW:0] Depth = (QueuePtrW + 1)'(QueueDepth);

    t_job                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, r_rd;
    logic [QueuePtrW:0]   r_count;

    assign o_full  = (r_count == Depth);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Depth)
        else $error("job queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("job queue lost a push");

endmodule

`default_nettype wire

// File: rtl/core/clnib_back.sv
// bus sequencer: walks each job one nibble at a time into the output register
`default_nettype none

module clnib_back
    import clnib_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_stall
);

    logic [3:0] r_idx, n_idx;
    logic       r_out_valid;
    t_out_item  r_out, n_out;
    logic       load;
    logic       is_last;
    logic [7:0] cur_byte;

    assign load = i_job_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out.cursor_column = i_job.column;
        n_out.cursor_row    = i_job.row;
        // second byte of a wrap is the line move command
        if (i_job.kind == JOB_WRAP && r_idx[1]) begin
            cur_byte              = i_job.wrap_byte;
            n_out.register_select = 1'b0;
        end else begin
            cur_byte              = i_job.first_byte;
            n_out.register_select = i_job.rs;
        end
        case (i_job.kind)
            JOB_INIT: begin
                is_last               = (r_idx == INIT_LAST_IDX);
                n_out.register_select = 1'b0;
                n_out.nibble          = init_nibble(r_idx);
            end
            JOB_WRAP: begin
                is_last      = (r_idx == WRAP_LAST_IDX);
                n_out.nibble = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
            end
            default: begin
                is_last      = (r_idx == BYTE_LAST_IDX);
                n_out.nibble = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
            end
        endcase
        n_out.last = is_last;
        n_idx      = is_last ? 4'd0 : r_idx + 4'd1;
    end

    assign o_pop       = load && is_last;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= n_idx;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    a_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_valid |-> r_idx == 4'd0)
        else $error("nibble index left mid job with no job queued");

    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && is_last |=> r_idx == 4'd0 && r_out_valid && r_out.last)
        else $error("final nibble did not rewind the index");

endmodule

`default_nettype wire

// File: rtl/core/char_lcd_nibble_interface.sv
// top level of the character display 4-bit bus interface
//
// Each accepted item becomes a run of 4-bit bus writes on the output channel,
// one per cycle while the output is not stalled: 2 for clear, line moves, raw
// commands and plain characters, 4 for a character in the last column (data
// plus the move to the other line), 14 for init. The input side takes one
// item per cycle as long as the four-entry job queue has room; the output
// register in the sequencer sets the unstalled rate at one nibble per cycle.
// Unused command codes are accepted and produce nothing. Cursor column and
// row in each result are the tracked position after that item.
`default_nettype none

module char_lcd_nibble_interface
    import clnib_pkg::*;
#(
    parameter int COLUMNS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_item,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_item,
    input  wire logic      i_out_stall
);

    logic push, pop, full, job_valid;
    t_job push_job, head_job;

    clnib_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    clnib_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    clnib_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for the character display 4-bit bus interface
`timescale 1ns / 1ps

module testbench;
    import clnib_pkg::*;

    localparam int LINE_COLS      = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 260;
    localparam int CALM_TAIL      = 40;

    // bus write predictor with its own copy of the tracked cursor
    class lcd_bus_scoreboard;
        t_out_item  pending_writes[$];
        logic [3:0] column;
        logic       row;
        int         errors;

        function new();
            column = '0;
            row    = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        function void note_command(t_in_item it);
            logic [4:0] nibbles[$];
            logic [8:0] bytes_out[$];
            logic [7:0] init_bytes[5];
            t_out_item  exp_w;
            init_bytes = '{8'h2C, 8'h0C, 8'h06, 8'h14, 8'h01};
            case (it.command)
                CMD_INIT: begin
                    column = '0;
                    row    = 1'b0;
                    nibbles = '{5'h03, 5'h03, 5'h03, 5'h02};
                    foreach (init_bytes[k]) bytes_out.push_back({1'b0, init_bytes[k]});
                end
                CMD_CHAR: begin
                    bytes_out.push_back({1'b1, it.data_byte});
                    if (column == 4'(LINE_COLS - 1)) begin
                        column = '0;
                        row    = !row;
                        bytes_out.push_back({1'b0, row ? BYTE_LINE2 : BYTE_LINE1});
                    end else begin
                        column = column + 4'd1;
                    end
                end
                CMD_CLEAR: begin
                    column = '0;
                    row    = 1'b0;
                    bytes_out.push_back({1'b0, BYTE_CLEAR});
                end
                CMD_LINE1: begin
                    column = '0;
                    row    = 1'b0;
                    bytes_out.push_back({1'b0, BYTE_LINE1});
                end
                CMD_LINE2: begin
                    column = '0;
                    row    = 1'b1;
                    bytes_out.push_back({1'b0, BYTE_LINE2});
                end
                CMD_RAW: begin
                    // position is not tracked through raw bytes
                    bytes_out.push_back({1'b0, it.data_byte});
                end
                default: begin
                    return;
                end
            endcase
            foreach (bytes_out[k]) begin
                nibbles.push_back({bytes_out[k][8], bytes_out[k][7:4]});
                nibbles.push_back({bytes_out[k][8], bytes_out[k][3:0]});
            end
            foreach (nibbles[k]) begin
                exp_w.register_select = nibbles[k][4];
                exp_w.nibble          = nibbles[k][3:0];
                exp_w.last            = (k == nibbles.size() - 1);
                exp_w.cursor_column   = column;
                exp_w.cursor_row      = row;
                pending_writes.push_back(exp_w);
            end
        endfunction

        function void check_write(t_out_item got);
            t_out_item exp_w;
            if (pending_writes.size() == 0) begin
                $error("bus write with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_w = pending_writes.pop_front();
            if (got.register_select !== exp_w.register_select) begin
                $error("register_select: expected %0d, actual %0d",
                       exp_w.register_select, got.register_select);
                errors++;
            end
            if (got.nibble !== exp_w.nibble) begin
                $error("nibble: expected %0h, actual %0h", exp_w.nibble, got.nibble);
                errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("last: expected %0d, actual %0d", exp_w.last, got.last);
                errors++;
            end
            if (got.cursor_column !== exp_w.cursor_column) begin
                $error("cursor_column: expected %0d, actual %0d",
                       exp_w.cursor_column, got.cursor_column);
                errors++;
            end
            if (got.cursor_row !== exp_w.cursor_row) begin
                $error("cursor_row: expected %0d, actual %0d",
                       exp_w.cursor_row, got.cursor_row);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    lcd_bus_scoreboard sb = new();

    bit idle_on = 1'b0;
    bit calm    = 1'b0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int chars_sent   = 0;

    char_lcd_nibble_interface #(
        .COLUMNS(LINE_COLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_item  (in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(out_stall)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // monitor: notes accepted commands, checks bus writes, drives the output stall
    always @(posedge i_clk) begin
        logic in_acc;
        logic out_acc;
        in_acc  = i_rst_n && in_valid && (o_in_stall === 1'b0);
        out_acc = i_rst_n && (o_out_valid === 1'b1) && !out_stall;
        if (in_acc) sb.note_command(in_item);
        if (out_acc) sb.check_write(o_out_item);

        if (stall_left > 0) stall_left--;
        else if (idle_on && !calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 18);
        out_stall <= (stall_left > 0);

        if (in_acc || out_acc || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_command(input logic [2:0] cmd, input logic [7:0] data);
        t_in_item it;
        it.command   = cmd;
        it.data_byte = data;
        if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (cmd <= CMD_RAW) chars_sent++;
    endtask

    task automatic send_any();
        send_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int run_len;
        logic [2:0] lead;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every command, byte extremes, unused codes
        idle_on = 1'b1;
        send_command(CMD_INIT,  8'h00);
        send_command(CMD_RAW,   8'h00);
        send_command(CMD_RAW,   8'hFF);
        send_command(CMD_CHAR,  8'h00);
        send_command(CMD_CHAR,  8'hFF);
        send_command(CMD_CLEAR, 8'hFF);
        send_command(CMD_LINE2, 8'h00);
        send_command(CMD_CHAR,  8'h41);
        send_command(3'd6,      8'hAA);
        send_command(CMD_LINE1, 8'h55);
        send_command(3'd7,      8'h55);
        send_command(CMD_RAW,   BYTE_LINE2);
        send_command(CMD_CHAR,  8'h7E);
        send_command(CMD_INIT,  8'hFF);
        send_command(CMD_LINE2, 8'hFF);
        // fill the second line to wrap back to the first
        repeat (LINE_COLS + 1) send_command(CMD_CHAR, 8'($urandom_range(0, 255)));

        while (chars_sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            calm    = (chars_sent >= RANDOM_ITEMS - CALM_TAIL);
            if ($urandom_range(0, 9) < 7) begin
                // long character runs so both line wraps are reached
                if ($urandom_range(0, 1) == 1) begin
                    lead = 3'($urandom_range(CMD_CLEAR, CMD_LINE2));
                    if ($urandom_range(0, 7) == 0) lead = CMD_INIT;
                    send_command(lead, 8'($urandom_range(0, 255)));
                end
                run_len = $urandom_range(10, 40);
                repeat (run_len) send_command(CMD_CHAR, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) send_any();
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/clnib_pkg.sv
rtl/core/clnib_front.sv
rtl/core/clnib_queue.sv
rtl/core/clnib_back.sv
rtl/core/char_lcd_nibble_interface.sv
dv/testbench.sv
